// ----- src/capde_pkg.sv -----
package capde_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 15;
  localparam int WET_W      = 16;
  localparam int CLEN_W     = 14;
  localparam int ALEN_W     = 11;
  localparam int LINE_W     = 32;
  localparam int IN_SHIFT   = 8;
  localparam int Q15_SHIFT  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default line depths.
  localparam int COMB_DEPTH_DEF    = 8192;
  localparam int ALLPASS_DEPTH_DEF = 1024;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AP_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AP_LEN     = 3'd4;

  // Register reset values.
  localparam logic [GAIN_W-1:0] COMB_GAIN_RST = 15'd26378;
  localparam logic [GAIN_W-1:0] AP_GAIN_RST   = 15'd22938;
  localparam logic [WET_W-1:0]  WET_MIX_RST   = 16'd16384;
  localparam logic [CLEN_W-1:0] COMB_LEN_RST  = 14'd6500;
  localparam logic [ALEN_W-1:0] AP_LEN_RST    = 11'd960;

  // Unity in Q1.15.
  localparam logic [WET_W:0] Q15_ONE = 17'd32768;

  typedef struct packed {
    logic [GAIN_W-1:0] comb_gain;
    logic [GAIN_W-1:0] ap_gain;
    logic [WET_W-1:0]  wet_mix;
    logic [CLEN_W-1:0] comb_len;
    logic [ALEN_W-1:0] ap_len;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // zero the swept word of each line within its depth
    logic load;     // capture the input transaction
    logic rd_line;  // read both delay lines
    logic prod_c;   // gain products of the comb word
    logic sum_c;    // comb feedback word and allpass output
    logic prod_y;   // allpass feedback and mix products
    logic commit;   // load result; with the effect on, also write lines and advance pointers
  } cmd_t;

  typedef struct packed {
    logic clr_last; // clearing pass writes its last word this cycle
  } sts_t;

  // Saturate a 34-bit sum to the signed 32-bit range.
  function automatic logic signed [LINE_W-1:0] sat32(input logic signed [LINE_W+1:0] v);
    logic signed [LINE_W-1:0] r;
    if (!v[LINE_W+1] && (v[LINE_W] || v[LINE_W-1])) begin
      r = {1'b0, {(LINE_W-1){1'b1}}};
    end else if (v[LINE_W+1] && !(v[LINE_W] && v[LINE_W-1])) begin
      r = {1'b1, {(LINE_W-1){1'b0}}};
    end else begin
      r = v[LINE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/capde_ctrl.sv -----
module capde_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              in_on_i,
  input  logic              m_tready_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  output capde_pkg::cmd_t   cmd_o,
  input  capde_pkg::sts_t   sts_i
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_PRODC = 3'd3;
  localparam logic [2:0] ST_SUMC  = 3'd4;
  localparam logic [2:0] ST_PRODY = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       outv_q, outv_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = in_on_i ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.rd_line = 1'b1;
        state_d       = ST_PRODC;
      end
      ST_PRODC: begin
        cmd_o.prod_c = 1'b1;
        state_d      = ST_SUMC;
      end
      ST_SUMC: begin
        cmd_o.sum_c = 1'b1;
        state_d     = ST_PRODY;
      end
      ST_PRODY: begin
        cmd_o.prod_y = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // The result register must be free or emptying this cycle.
        if (!outv_q || m_tready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    outv_d = outv_q;
    if (cmd_o.commit) begin
      outv_d = 1'b1;
    end else if (m_tready_i) begin
      outv_d = 1'b0;
    end
  end

  assign m_tvalid_o = outv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      outv_q  <= outv_d;
    end
  end

endmodule

// ----- src/capde_dp.sv -----
module capde_dp #(
  parameter int COMB_DEPTH    = capde_pkg::COMB_DEPTH_DEF,
  parameter int ALLPASS_DEPTH = capde_pkg::ALLPASS_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  capde_pkg::cmd_t                  cmd_i,
  output capde_pkg::sts_t                  sts_o,
  input  capde_pkg::cfg_t                  cfg_i,
  input  logic [capde_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                             on_i,
  output logic [capde_pkg::SAMPLE_W-1:0]   sample_o
);

  localparam int LW    = capde_pkg::LINE_W;
  localparam int SW    = capde_pkg::SAMPLE_W;
  localparam int GW    = capde_pkg::GAIN_W;
  localparam int WW    = capde_pkg::WET_W;
  localparam int XW    = SW + capde_pkg::IN_SHIFT;
  localparam int QS    = capde_pkg::Q15_SHIFT;
  localparam int PW    = LW + GW;             // gain product width
  localparam int DRYW  = WW + XW;             // dry product width
  localparam int WETPW = WW + 1 + LW;         // wet product width
  localparam int MIXW  = WETPW + 1;
  localparam int MSH   = QS + capde_pkg::IN_SHIFT;
  localparam int CW    = $clog2(COMB_DEPTH);
  localparam int AW    = $clog2(ALLPASS_DEPTH);
  localparam int CEW   = (capde_pkg::CLEN_W > CW + 1) ? capde_pkg::CLEN_W : CW + 1;
  localparam int AEW   = (capde_pkg::ALEN_W > AW + 1) ? capde_pkg::ALEN_W : AW + 1;
  localparam int CLR_N = (COMB_DEPTH > ALLPASS_DEPTH) ? COMB_DEPTH : ALLPASS_DEPTH;
  localparam int CLRW  = $clog2(CLR_N);

  logic signed [LW-1:0] comb_mem [COMB_DEPTH];
  logic signed [LW-1:0] ap_mem   [ALLPASS_DEPTH];

  logic [CW-1:0]          comb_ptr_q, comb_ptr_d;
  logic [AW-1:0]          ap_ptr_q, ap_ptr_d;
  logic [CLRW-1:0]        clr_q, clr_d;
  logic [SW-1:0]          sample_q;
  logic                   on_q;
  logic signed [LW-1:0]   c_q, a_q;
  logic signed [PW-1:0]   pcg_q, pca_q, pyg_q;
  logic signed [LW-1:0]   comb_new_q, y_q;
  logic [DRYW-1:0]        pdry_q;
  logic signed [WETPW-1:0] pwet_q;
  logic [SW-1:0]          out_q;

  logic [XW-1:0]          x;
  logic signed [LW+1:0]   comb_sum, y_sum, ap_sum;
  logic signed [LW-1:0]   ap_new;
  logic [WW-1:0]          wet_eff, dry_eff;
  logic signed [MIXW-1:0] mix;
  logic signed [MIXW-MSH-1:0] mix_sh;
  logic [SW-1:0]          mix_clamp;
  logic [CEW-1:0]         comb_len_eff, comb_nxt;
  logic [AEW-1:0]         ap_len_eff, ap_nxt;
  logic                   comb_we, ap_we;
  logic [CW-1:0]          comb_wa;
  logic [AW-1:0]          ap_wa;
  logic signed [LW-1:0]   comb_wd, ap_wd;

  assign x = {sample_q, {capde_pkg::IN_SHIFT{1'b0}}};

  // Effective lengths: zero acts as one, beyond the depth acts as the depth.
  always_comb begin
    if (cfg_i.comb_len == '0) begin
      comb_len_eff = CEW'(1);
    end else if (CEW'(cfg_i.comb_len) > CEW'(COMB_DEPTH)) begin
      comb_len_eff = CEW'(COMB_DEPTH);
    end else begin
      comb_len_eff = CEW'(cfg_i.comb_len);
    end
    if (cfg_i.ap_len == '0) begin
      ap_len_eff = AEW'(1);
    end else if (AEW'(cfg_i.ap_len) > AEW'(ALLPASS_DEPTH)) begin
      ap_len_eff = AEW'(ALLPASS_DEPTH);
    end else begin
      ap_len_eff = AEW'(cfg_i.ap_len);
    end
  end

  assign comb_nxt   = CEW'(comb_ptr_q) + CEW'(1);
  assign ap_nxt     = AEW'(ap_ptr_q) + AEW'(1);
  assign comb_ptr_d = (comb_nxt >= comb_len_eff) ? '0 : comb_nxt[CW-1:0];
  assign ap_ptr_d   = (ap_nxt >= ap_len_eff) ? '0 : ap_nxt[AW-1:0];

  // Comb feedback word and allpass output, each saturated. The shifted gain
  // products are signed and are sign-extended before the sums.
  assign comb_sum = (LW+2)'($signed(pcg_q[PW-1:QS])) + $signed({{(LW+2-XW){1'b0}}, x});
  assign y_sum    = (LW+2)'(a_q) - (LW+2)'($signed(pca_q[PW-1:QS]));
  assign ap_sum   = (LW+2)'($signed(pyg_q[PW-1:QS])) + (LW+2)'(c_q);
  assign ap_new   = capde_pkg::sat32(ap_sum);

  assign wet_eff = ((WW+1)'(cfg_i.wet_mix) > capde_pkg::Q15_ONE) ?
                   capde_pkg::Q15_ONE[WW-1:0] : cfg_i.wet_mix;
  assign dry_eff = WW'(capde_pkg::Q15_ONE - (WW+1)'(wet_eff));

  assign mix    = $signed({1'b0, pdry_q}) + MIXW'(pwet_q);
  assign mix_sh = mix[MIXW-1:MSH];

  always_comb begin
    if (mix_sh[MIXW-MSH-1]) begin
      mix_clamp = '0;
    end else if (|mix_sh[MIXW-MSH-2:SW]) begin
      mix_clamp = '1;
    end else begin
      mix_clamp = mix_sh[SW-1:0];
    end
  end

  // Clearing pass sweeps both lines after reset.
  assign clr_d           = clr_q + CLRW'(1);
  assign sts_o.clr_last  = cmd_i.clear && (clr_q == CLRW'(CLR_N - 1));

  always_comb begin
    comb_we = 1'b0;
    ap_we   = 1'b0;
    comb_wa = comb_ptr_q;
    ap_wa   = ap_ptr_q;
    comb_wd = comb_new_q;
    ap_wd   = ap_new;
    if (cmd_i.clear) begin
      comb_we = (CLRW+1)'(clr_q) < (CLRW+1)'(COMB_DEPTH);
      ap_we   = (CLRW+1)'(clr_q) < (CLRW+1)'(ALLPASS_DEPTH);
      comb_wa = clr_q[CW-1:0];
      ap_wa   = clr_q[AW-1:0];
      comb_wd = '0;
      ap_wd   = '0;
    end else if (cmd_i.commit && on_q) begin
      comb_we = 1'b1;
      ap_we   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (comb_we) begin
      comb_mem[comb_wa] <= comb_wd;
    end
    if (cmd_i.rd_line) begin
      c_q <= comb_mem[comb_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ap_we) begin
      ap_mem[ap_wa] <= ap_wd;
    end
    if (cmd_i.rd_line) begin
      a_q <= ap_mem[ap_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      on_q     <= on_i;
    end
    if (cmd_i.prod_c) begin
      pcg_q <= c_q * $signed({1'b0, cfg_i.comb_gain});
      pca_q <= c_q * $signed({1'b0, cfg_i.ap_gain});
    end
    if (cmd_i.sum_c) begin
      comb_new_q <= capde_pkg::sat32(comb_sum);
      y_q        <= capde_pkg::sat32(y_sum);
    end
    if (cmd_i.prod_y) begin
      pyg_q  <= y_q * $signed({1'b0, cfg_i.ap_gain});
      pdry_q <= dry_eff * x;
      pwet_q <= y_q * $signed({1'b0, wet_eff});
    end
    if (cmd_i.commit) begin
      out_q <= on_q ? mix_clamp : sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comb_ptr_q <= '0;
      ap_ptr_q   <= '0;
      clr_q      <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_d;
      end
      if (cmd_i.commit && on_q) begin
        comb_ptr_q <= comb_ptr_d;
        ap_ptr_q   <= ap_ptr_d;
      end
    end
  end

  assign sample_o = out_q;

endmodule

// ----- src/comb_allpass_delay_effect.sv -----
// Comb plus allpass delay effect for a stream of 16-bit unsigned audio samples.
//
// Input channel (s_axis): one transaction carries one sample in tdata and the
// effect switch in tuser. Output channel (m_axis): one transaction per input
// transaction, carrying the mixed sample. Gains, wet fraction and line lengths
// must be written via the cfg port while the block is idle (not enforced).
//
// The block works on one sample at a time. With the effect on, a sample goes
// through the accept step, the registered read of both delay memories, the
// gain multipliers, the comb and allpass sums, the mix multipliers, and a
// final step that writes both lines back and loads the result register. In
// bypass the accepted sample goes straight to that final step, which loads
// it into the result register.
//
// After reset the block sweeps both delay memories to zero, one word per cycle,
// over max(COMB_DEPTH, ALLPASS_DEPTH) words (8192 by default); s_axis_tready
// stays low until that pass ends. The result register lets the next sample be
// accepted while a result still waits; if the receiver stalls, the block holds
// in its write-back cycle until the result register frees up.
module comb_allpass_delay_effect #(
  parameter int COMB_DEPTH    = capde_pkg::COMB_DEPTH_DEF,
  parameter int ALLPASS_DEPTH = capde_pkg::ALLPASS_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [capde_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // [15:0] sample_in
  input  logic                               s_axis_tuser,  // [0] effect_on
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [capde_pkg::SAMPLE_W-1:0]     m_axis_tdata,  // [15:0] sample_out
  input  logic                               cfg_we_i,
  input  logic [capde_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [capde_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  capde_pkg::cfg_t cfg_q;
  capde_pkg::cmd_t cmd;
  capde_pkg::sts_t sts;

  // Configuration registers. Each write keeps the low bits that fit the
  // register; writes to an unknown index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comb_gain <= capde_pkg::COMB_GAIN_RST;
      cfg_q.ap_gain   <= capde_pkg::AP_GAIN_RST;
      cfg_q.wet_mix   <= capde_pkg::WET_MIX_RST;
      cfg_q.comb_len  <= capde_pkg::COMB_LEN_RST;
      cfg_q.ap_len    <= capde_pkg::AP_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        capde_pkg::REG_COMB_GAIN: begin
          cfg_q.comb_gain <= cfg_data_i[capde_pkg::GAIN_W-1:0];
        end
        capde_pkg::REG_AP_GAIN: begin
          cfg_q.ap_gain <= cfg_data_i[capde_pkg::GAIN_W-1:0];
        end
        capde_pkg::REG_WET_MIX: begin
          cfg_q.wet_mix <= cfg_data_i[capde_pkg::WET_W-1:0];
        end
        capde_pkg::REG_COMB_LEN: begin
          cfg_q.comb_len <= cfg_data_i[capde_pkg::CLEN_W-1:0];
        end
        capde_pkg::REG_AP_LEN: begin
          cfg_q.ap_len <= cfg_data_i[capde_pkg::ALEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The controller sequences the clearing pass and each sample's steps.
  capde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .in_on_i    (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The datapath holds both delay memories, their pointers and the arithmetic.
  capde_dp #(
    .COMB_DEPTH    (COMB_DEPTH),
    .ALLPASS_DEPTH (ALLPASS_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .cfg_i    (cfg_q),
    .sample_i (s_axis_tdata),
    .on_i     (s_axis_tuser),
    .sample_o (m_axis_tdata)
  );

endmodule
